[hdl/mlhc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_pkg: shared definitions of the multi-level hysteresis classifier
// Widths, reset tables, rounding constants and controller/datapath structs.
// ----------------------------------------------------------------------------
package mlhc_pkg;

	localparam int NUM_LEVELS   = 8;
	localparam int NUM_THRESH   = NUM_LEVELS - 1;
	localparam int SAMPLE_BITS  = 12;
	localparam int RAW_W        = 16;
	localparam int SAMPLE_SHIFT = (SAMPLE_BITS >= 15) ? 0 : 15 - SAMPLE_BITS;
	localparam int POINT_W      = 12;
	localparam int POINT_IDX_W  = 3;
	localparam int THR_W        = 12;
	localparam int HYST_W       = 9;
	localparam int LEVEL_W      = $clog2(NUM_LEVELS + 1);
	localparam int CNT_W        = $clog2(NUM_LEVELS + 1);
	localparam int TIDX_W       = $clog2(NUM_THRESH);
	localparam int LIM_W        = THR_W + 2;

	localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = LEVEL_W'(NUM_LEVELS);
	localparam logic [HYST_W-1:0]  MIN_HYST_RST  = HYST_W'(5);

	// (gap + 5) / 10 as a multiplication by 3277 / 2^15, exact below 2^14.
	localparam int GAP_W       = POINT_W + 1;
	localparam int RECIP_W     = 12;
	localparam int RECIP_SHIFT = 15;
	localparam int PROD_W      = GAP_W + RECIP_W;
	localparam int BAND_W      = HYST_W + 1;
	localparam logic [RECIP_W-1:0] RECIP_MUL  = RECIP_W'(3277);
	localparam logic [GAP_W-1:0]   ROUND_BIAS = GAP_W'(5);
	localparam logic [BAND_W-1:0]  BAND_MAX   = BAND_W'((1 << HYST_W) - 1);

	typedef logic [THR_W-1:0]   thr_t;
	typedef logic [HYST_W-1:0]  hyst_t;
	typedef logic [POINT_W-1:0] point_t;
	typedef logic [LEVEL_W-1:0] level_t;

	typedef struct packed {
		logic                   take;
		logic                   rd_en;
		logic [POINT_IDX_W-1:0] rd_addr;
		logic                   tab_we;
		logic [TIDX_W-1:0]      tab_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic out_blocked;
		logic commit_req;
	} dp_status_t;

	function automatic thr_t thr_default(input int idx);
		thr_t v;
		case (idx)
			0: v = THR_W'(458);
			1: v = THR_W'(495);
			2: v = THR_W'(545);
			3: v = THR_W'(590);
			4: v = THR_W'(810);
			5: v = THR_W'(1150);
			6: v = THR_W'(1800);
			default: v = '0;
		endcase
		return v;
	endfunction

	function automatic hyst_t hyst_default(input int idx);
		hyst_t v;
		case (idx)
			0: v = HYST_W'(4);
			1: v = HYST_W'(5);
			2: v = HYST_W'(10);
			3: v = HYST_W'(20);
			4: v = HYST_W'(30);
			5: v = HYST_W'(50);
			6: v = HYST_W'(70);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

[hdl/mlhc_item_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_item_if: input channel of the classifier
// Carries one sample or calibration point per transaction.
// ----------------------------------------------------------------------------
interface mlhc_item_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic signed [mlhc_pkg::RAW_W-1:0]   raw_sample;
	logic [mlhc_pkg::POINT_IDX_W-1:0]    point_index;
	logic [mlhc_pkg::POINT_W-1:0]        point_value;

	modport source (output valid, kind, raw_sample, point_index, point_value, input ready);
	modport sink   (input valid, kind, raw_sample, point_index, point_value, output ready);
endinterface
`default_nettype wire

[hdl/mlhc_result_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_result_if: output channel of the classifier
// Carries the position, the changed flag and the clamped sample.
// ----------------------------------------------------------------------------
interface mlhc_result_if;
	logic                              valid;
	logic                              ready;
	logic [mlhc_pkg::LEVEL_W-1:0]      position;
	logic                              changed;
	logic [mlhc_pkg::SAMPLE_BITS-1:0]  sample_value;

	modport source (output valid, position, changed, sample_value, input ready);
	modport sink   (input valid, position, changed, sample_value, output ready);
endinterface
`default_nettype wire

[hdl/multi_level_hysteresis_classifier_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multi_level_hysteresis_classifier_core: multi-level hysteresis classifier
// Sorts clamped converter samples into ordered positions with per-threshold
// hysteresis, and rebuilds thresholds and bands from calibration points.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Contents
//  item      in         valid/ready    kind, raw_sample, point_index, point_value
//  result    out        valid/ready    position, changed, sample_value
//  cfg       in         cfg_wr_en      cfg_wr_data = min_hysteresis (9 bits)
//
// Every input transaction yields exactly one result transaction. A sample or
// a non-final calibration point is handled in the accepting cycle and its
// result sits in the output register from the next cycle, so one item per
// cycle flows while the result side keeps up. The final calibration point
// (last position) also starts a commit walk over the point memory: one read
// per cycle for eight points, then a drain step; no item is taken during
// the walk, whose pace is set by the single read port of the point memory.
// A stalled result blocks new items only while it is not taken. Reset loads
// the factory thresholds and bands, an unknown position and a floor of 5.
//
// Structure: mlhc_ctrl holds the admission and commit sequencing, mlhc_dp
// holds the tables, the level register, the point memory and the output
// register. They talk only through the command and status structs.
// ----------------------------------------------------------------------------
module multi_level_hysteresis_classifier_core (
	input  wire                          clk,
	input  wire                          arst_n,
	mlhc_item_if.sink                    item,
	mlhc_result_if.source                result,
	input  wire                          cfg_wr_en,
	input  wire [mlhc_pkg::HYST_W-1:0]   cfg_wr_data
);

	mlhc_pkg::ctrl_cmd_t  cmd;
	mlhc_pkg::dp_status_t status;

	// Controller: accepts transactions when idle and the output register is
	// free, and steps the commit through point reads and table writes.
	mlhc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.cmd    (cmd)
	);

	// Datapath: classification is combinational from the accepted sample to
	// the output register; the commit computes one threshold pair per cycle.
	mlhc_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.result      (result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd         (cmd),
		.status      (status)
	);

endmodule
`default_nettype wire

[hdl/mlhc_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_ctrl: classifier controller
// Admits transactions and sequences the calibration commit walk.
// ----------------------------------------------------------------------------
module mlhc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  mlhc_pkg::dp_status_t status,
	output mlhc_pkg::ctrl_cmd_t  cmd
);

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_COMMIT = 1'b1;

	logic                        state_q;
	logic [mlhc_pkg::CNT_W-1:0]  cnt_q;
	logic [mlhc_pkg::CNT_W-1:0]  tab_cnt;
	logic                        walk_last;

	assign tab_cnt   = cnt_q - mlhc_pkg::CNT_W'(2);
	assign walk_last = (cnt_q == mlhc_pkg::CNT_W'(mlhc_pkg::NUM_LEVELS));

	always_comb begin
		cmd.take    = (state_q == ST_IDLE) && !status.out_blocked;
		cmd.rd_en   = (state_q == ST_COMMIT) && (cnt_q < mlhc_pkg::CNT_W'(mlhc_pkg::NUM_LEVELS));
		cmd.rd_addr = cnt_q[mlhc_pkg::POINT_IDX_W-1:0];
		cmd.tab_we  = (state_q == ST_COMMIT) && (cnt_q >= mlhc_pkg::CNT_W'(2));
		cmd.tab_idx = tab_cnt[mlhc_pkg::TIDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.take && status.commit_req) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					cnt_q <= cnt_q + mlhc_pkg::CNT_W'(1);
					if (walk_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/mlhc_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_dp: classifier datapath
// Threshold compare, level register, point memory, commit arithmetic, output.
// ----------------------------------------------------------------------------
module mlhc_dp (
	input  wire                                 clk,
	input  wire                                 arst_n,
	mlhc_item_if.sink                           item,
	mlhc_result_if.source                       result,
	input  wire                                 cfg_wr_en,
	input  wire [mlhc_pkg::HYST_W-1:0]          cfg_wr_data,
	input  mlhc_pkg::ctrl_cmd_t                 cmd,
	output mlhc_pkg::dp_status_t                status
);

	localparam int NT = mlhc_pkg::NUM_THRESH;

	mlhc_pkg::thr_t    thr_q [NT];
	mlhc_pkg::hyst_t   hys_q [NT];
	mlhc_pkg::point_t  pts_mem [mlhc_pkg::NUM_LEVELS];
	mlhc_pkg::point_t  rd_data_q;
	mlhc_pkg::point_t  prev_q;
	mlhc_pkg::hyst_t   min_hyst_q;
	mlhc_pkg::level_t  level_q;

	logic                              out_valid_q;
	mlhc_pkg::level_t                  out_pos_q;
	logic                              out_chg_q;
	logic [mlhc_pkg::SAMPLE_BITS-1:0]  out_smp_q;

	logic                              fire;
	logic [mlhc_pkg::SAMPLE_BITS-1:0]  sample;
	logic signed [mlhc_pkg::LIM_W-1:0] sample_s;
	logic signed [mlhc_pkg::LIM_W-1:0] lim [NT];
	logic [NT-1:0]                     below;
	mlhc_pkg::level_t                  new_lvl;

	mlhc_pkg::point_t                  gap;
	logic [mlhc_pkg::GAP_W-1:0]        gap_b;
	logic [mlhc_pkg::PROD_W-1:0]       prod;
	logic [mlhc_pkg::BAND_W-1:0]       band;
	logic [mlhc_pkg::BAND_W-1:0]       band_fl;
	mlhc_pkg::hyst_t                   band_sat;
	logic [mlhc_pkg::POINT_W:0]        pair_sum;
	mlhc_pkg::thr_t                    mean;

	assign fire = item.valid && cmd.take;
	assign item.ready = cmd.take;

	assign status.out_blocked = out_valid_q && !result.ready;
	assign status.commit_req  = item.valid && item.kind &&
		(item.point_index == mlhc_pkg::POINT_IDX_W'(mlhc_pkg::NUM_LEVELS - 1));

	// Negative readings clamp to zero.
	assign sample = item.raw_sample[mlhc_pkg::RAW_W-1] ? '0 :
		item.raw_sample[mlhc_pkg::SAMPLE_SHIFT +: mlhc_pkg::SAMPLE_BITS];
	assign sample_s = $signed({{(mlhc_pkg::LIM_W-mlhc_pkg::SAMPLE_BITS){1'b0}}, sample});

	// Band around the current level: widened at it, narrowed at its neighbours.
	always_comb begin
		for (int t = 0; t < NT; t++) begin
			logic signed [mlhc_pkg::LIM_W-1:0] thr_s;
			logic signed [mlhc_pkg::LIM_W-1:0] hys_s;
			thr_s = $signed({{(mlhc_pkg::LIM_W-mlhc_pkg::THR_W){1'b0}}, thr_q[t]});
			hys_s = $signed({{(mlhc_pkg::LIM_W-mlhc_pkg::HYST_W){1'b0}}, hys_q[t]});
			if (level_q == mlhc_pkg::LEVEL_UNKNOWN) begin
				lim[t] = thr_s;
			end else if (mlhc_pkg::LEVEL_W'(t) == level_q) begin
				lim[t] = thr_s + hys_s;
			end else if ((mlhc_pkg::LEVEL_W'(t + 1) == level_q) ||
				(mlhc_pkg::LEVEL_W'(t) == level_q + mlhc_pkg::LEVEL_W'(1))) begin
				lim[t] = thr_s - hys_s;
			end else begin
				lim[t] = thr_s;
			end
			below[t] = sample_s < lim[t];
		end
	end

	always_comb begin
		new_lvl = mlhc_pkg::LEVEL_W'(NT);
		for (int t = NT - 1; t >= 0; t--) begin
			if (below[t]) begin
				new_lvl = mlhc_pkg::LEVEL_W'(t);
			end
		end
	end

	// Commit arithmetic on one neighbouring pair of points.
	assign gap      = (prev_q > rd_data_q) ? (prev_q - rd_data_q) : (rd_data_q - prev_q);
	assign gap_b    = {1'b0, gap} + mlhc_pkg::ROUND_BIAS;
	assign prod     = mlhc_pkg::PROD_W'(gap_b) * mlhc_pkg::PROD_W'(mlhc_pkg::RECIP_MUL);
	assign band     = prod[mlhc_pkg::RECIP_SHIFT +: mlhc_pkg::BAND_W];
	assign band_fl  = (band < {1'b0, min_hyst_q}) ? {1'b0, min_hyst_q} : band;
	assign band_sat = (band_fl > mlhc_pkg::BAND_MAX) ? '1 : band_fl[mlhc_pkg::HYST_W-1:0];
	assign pair_sum = {1'b0, prev_q} + {1'b0, rd_data_q};
	assign mean     = pair_sum[mlhc_pkg::POINT_W:1];

	always_ff @(posedge clk) begin
		if (fire && item.kind &&
			(item.point_index < mlhc_pkg::POINT_IDX_W'(mlhc_pkg::NUM_LEVELS - 1) ||
			 item.point_index == mlhc_pkg::POINT_IDX_W'(mlhc_pkg::NUM_LEVELS - 1))) begin
			pts_mem[item.point_index] <= item.point_value;
		end
		if (cmd.rd_en) begin
			rd_data_q <= pts_mem[cmd.rd_addr];
		end
		prev_q <= rd_data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < NT; t++) begin
				thr_q[t] <= mlhc_pkg::thr_default(t);
				hys_q[t] <= mlhc_pkg::hyst_default(t);
			end
			min_hyst_q  <= mlhc_pkg::MIN_HYST_RST;
			level_q     <= mlhc_pkg::LEVEL_UNKNOWN;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				min_hyst_q <= cfg_wr_data;
			end
			if (cmd.tab_we) begin
				thr_q[cmd.tab_idx] <= mean;
				hys_q[cmd.tab_idx] <= band_sat;
			end
			if (fire && !item.kind) begin
				level_q <= new_lvl;
			end
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_pos_q <= item.kind ? level_q : new_lvl;
			out_chg_q <= !item.kind && (new_lvl != level_q);
			out_smp_q <= item.kind ? '0 : sample;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.position     = out_pos_q;
	assign result.changed      = out_chg_q;
	assign result.sample_value = out_smp_q;

endmodule
`default_nettype wire

[hdl/mlhc_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mlhc_chk: port checker for the classifier
// Watches the item and result channels and the reported positions.
// ----------------------------------------------------------------------------
module mlhc_chk (
	input wire                                clk,
	input wire                                arst_n,
	input wire                                item_valid,
	input wire                                item_ready,
	input wire                                item_kind,
	input wire                                result_valid,
	input wire                                result_ready,
	input wire [mlhc_pkg::LEVEL_W-1:0]        position,
	input wire                                changed,
	input wire [mlhc_pkg::SAMPLE_BITS-1:0]    sample_value
);

	logic [mlhc_pkg::LEVEL_W-1:0] last_pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q <= mlhc_pkg::LEVEL_UNKNOWN;
		end else if (result_valid && result_ready) begin
			last_pos_q <= position;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(position) &&
		$stable(changed) && $stable(sample_value))
		else $error("result changed while stalled");

	a_position_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> position <= mlhc_pkg::LEVEL_UNKNOWN)
		else $error("position out of range");

	a_changed_flag: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_ready |-> changed == (position != last_pos_q))
		else $error("changed flag disagrees with position history");

	a_cal_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_kind |=>
		result_valid && !changed && sample_value == '0)
		else $error("calibration transaction gave a wrong result");

endmodule

bind multi_level_hysteresis_classifier_core mlhc_chk u_mlhc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.item_kind    (item.kind),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.position     (result.position),
	.changed      (result.changed),
	.sample_value (result.sample_value)
);
`default_nettype wire
